FILE: rtl/mf3_pkg.sv
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// mf3_pkg
// Shared types, constants and compare helpers for the 3x3 median filter core.
// ----------------------------------------------------------------------------
package mf3_pkg;

    // Field widths.
    localparam int PIX_W      = 8;
    localparam int CFG_W_W    = 11;
    localparam int CFG_H_W    = 12;
    localparam int ROW_W      = 13;
    localparam int APB_ADDR_W = 3;
    localparam int APB_DATA_W = 32;

    // Default line length and register reset values.
    localparam int MAX_WIDTH_DEF = 1024;
    localparam logic [CFG_W_W-1:0] WIDTH_RST  = CFG_W_W'(640);
    localparam logic [CFG_H_W-1:0] HEIGHT_RST = CFG_H_W'(480);

    // Register map, indexed by word address.
    typedef enum logic
    {
        REG_WIDTH  = 1'b0,
        REG_HEIGHT = 1'b1
    } cfg_reg_t;

    typedef logic [PIX_W-1:0] pix_t;

    function automatic pix_t min2(input pix_t a, input pix_t b);
        return (a < b) ? a : b;
    endfunction

    function automatic pix_t max2(input pix_t a, input pix_t b);
        return (a < b) ? b : a;
    endfunction

    function automatic pix_t min3(input pix_t a, input pix_t b, input pix_t c);
        return min2(min2(a, b), c);
    endfunction

    function automatic pix_t max3(input pix_t a, input pix_t b, input pix_t c);
        return max2(max2(a, b), c);
    endfunction

    // Middle value of three.
    function automatic pix_t med3(input pix_t a, input pix_t b, input pix_t c);
        return max2(min2(a, b), min2(max2(a, b), c));
    endfunction

endpackage

FILE: rtl/median_filter_3x3_core.sv
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// median_filter_3x3_core
// 3x3 median filter over an 8-bit raster stream with two line stores.
// ----------------------------------------------------------------------------
//
//  Channel   Handshake                    Payload
//  --------  ---------------------------  -------------------------------
//  input     in_valid / in_ready          in_pixel, flush
//  output    out_valid / out_ready        out_pixel, frame_last
//  config    psel, penable, pwrite, ...   paddr, pwdata, prdata
//
//  One item is taken per clock while in_ready is high. The line stores are
//  read when an item is accepted and written as it leaves stage 1, with a
//  forward for back to back hits on the same column. A result passes stages
//  1 to 4 to the output register. Reset clears control state and the window;
//  the line stores need no clearing. A stalled output backs up through the
//  pipeline and holds in_ready low only once every stage is full.
//
module median_filter_3x3_core
    import mf3_pkg::*;
#(
    parameter int MAX_WIDTH = MAX_WIDTH_DEF
)
(
    input  logic                  clk,
    input  logic                  rst_n,
    // Configuration port
    input  logic                  psel,
    input  logic                  penable,
    input  logic                  pwrite,
    input  logic [APB_ADDR_W-1:0] paddr,
    input  logic [APB_DATA_W-1:0] pwdata,
    output logic [APB_DATA_W-1:0] prdata,
    output logic                  pready,
    // Input items
    input  logic                  in_valid,
    output logic                  in_ready,
    input  logic [PIX_W-1:0]      in_pixel,
    input  logic                  flush,
    // Result items
    output logic                  out_valid,
    input  logic                  out_ready,
    output logic [PIX_W-1:0]      out_pixel,
    output logic                  frame_last
);

    localparam int ADDR_W = $clog2(MAX_WIDTH);
    localparam int COL_W  = $clog2(MAX_WIDTH + 1);

    // Configuration registers.
    logic [CFG_W_W-1:0] image_width_reg;
    logic [CFG_H_W-1:0] image_height_reg;
    logic               cfg_wr;

    // Position counters.
    logic [COL_W-1:0] col_reg, col_next;
    logic [ROW_W-1:0] row_reg, row_next;

    // Effective geometry and per-item decode.
    logic [COL_W-1:0]   w_eff;
    logic [CFG_H_W-1:0] h_eff;
    logic [COL_W-1:0]   cur_col;
    logic [ROW_W-1:0]   cur_row;
    logic               col_wrap, col_nz, produce, border, sel_med, end_frame;
    logic [PIX_W-1:0]   in_pix_eff;
    logic [ADDR_W-1:0]  rd_addr;
    logic               in_fire;

    // Line stores and their registered read data.
    logic [PIX_W-1:0] upper_mem [MAX_WIDTH];
    logic [PIX_W-1:0] middle_mem [MAX_WIDTH];
    logic [PIX_W-1:0] up_rd_reg, mid_rd_reg;

    // Stage 1: read data arrives, window shifts, stores are written.
    logic              s1_v_reg;
    logic [ADDR_W-1:0] s1_addr_reg;
    logic [PIX_W-1:0]  s1_pix_reg;
    logic              s1_prod_reg, s1_med_reg, s1_last_reg;
    logic              s1_fwd_reg;
    logic [PIX_W-1:0]  s1_fwd_up_reg, s1_fwd_mid_reg;
    logic [PIX_W-1:0]  s1_up, s1_mid;
    logic              s1_adv, s1_free;

    // 3x3 window, row-major with row 0 the oldest line.
    logic [PIX_W-1:0] win_reg [9];
    logic [PIX_W-1:0] win_shift [9];

    // Stage 2: window snapshot.
    logic             s2_v_reg, s2_med_reg, s2_last_reg;
    logic [PIX_W-1:0] s2_bval_reg;
    logic [PIX_W-1:0] s2_win_reg [9];
    logic             s2_free;

    // Stage 3: each row sorted.
    logic             s3_v_reg, s3_med_reg, s3_last_reg;
    logic [PIX_W-1:0] s3_bval_reg;
    logic [PIX_W-1:0] s3_lo_reg [3];
    logic [PIX_W-1:0] s3_md_reg [3];
    logic [PIX_W-1:0] s3_hi_reg [3];
    logic             s3_free;

    // Stage 4: max of lows, median of middles, min of highs.
    logic             s4_v_reg, s4_med_reg, s4_last_reg;
    logic [PIX_W-1:0] s4_bval_reg, s4_a_reg, s4_b_reg, s4_c_reg;
    logic             s4_free;

    // Output register.
    logic             out_v_reg, out_last_reg;
    logic [PIX_W-1:0] out_pix_reg;
    logic             out_free;

    // ------------------------------------------------------------------------
    // Configuration port
    // ------------------------------------------------------------------------

    // The port never stalls; a write lands in its access cycle.
    assign pready = 1'b1;
    assign cfg_wr = psel && penable && pwrite;

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            image_width_reg  <= WIDTH_RST;
            image_height_reg <= HEIGHT_RST;
        end
        else if (cfg_wr)
        begin
            case (cfg_reg_t'(paddr[2]))
                REG_WIDTH:  image_width_reg  <= pwdata[CFG_W_W-1:0];
                REG_HEIGHT: image_height_reg <= pwdata[CFG_H_W-1:0];
                default:    ;
            endcase
        end
    end

    // Register read back.
    always_comb
    begin
        case (cfg_reg_t'(paddr[2]))
            REG_WIDTH:  prdata = APB_DATA_W'(image_width_reg);
            REG_HEIGHT: prdata = APB_DATA_W'(image_height_reg);
            default:    prdata = '0;
        endcase
    end

    // ------------------------------------------------------------------------
    // Pipeline flow control
    // ------------------------------------------------------------------------

    assign out_free = !out_v_reg || out_ready;
    assign s4_free  = !s4_v_reg || out_free;
    assign s3_free  = !s3_v_reg || s4_free;
    assign s2_free  = !s2_v_reg || s3_free;
    assign s1_free  = !s1_v_reg || s2_free;
    assign s1_adv   = s1_v_reg && s2_free;
    assign in_ready = s1_free;
    assign in_fire  = in_valid && in_ready;

    // ------------------------------------------------------------------------
    // Position decode for the incoming item
    // ------------------------------------------------------------------------

    // Zero width or height acts as one, widths past the line store are clamped.
    always_comb
    begin
        if (image_width_reg == '0)
        begin
            w_eff = COL_W'(1);
        end
        else if (32'(image_width_reg) > 32'(MAX_WIDTH))
        begin
            w_eff = COL_W'(MAX_WIDTH);
        end
        else
        begin
            w_eff = COL_W'(image_width_reg);
        end
        h_eff = (image_height_reg == '0) ? CFG_H_W'(1) : image_height_reg;
    end

    always_comb
    begin
        col_wrap   = col_reg >= w_eff;
        cur_col    = col_wrap ? '0 : col_reg;
        cur_row    = col_wrap ? row_reg + ROW_W'(1) : row_reg;
        col_nz     = cur_col != '0;
        produce    = (cur_row >= ROW_W'(2)) || ((cur_row == ROW_W'(1)) && col_nz);
        border     = (cur_row == ROW_W'(1)) || (cur_row >= ROW_W'(h_eff))
                     || (cur_col == COL_W'(1)) || (cur_col >= w_eff);
        sel_med    = col_nz && !border;
        end_frame  = produce && !col_nz && (cur_row >= ROW_W'(h_eff) + ROW_W'(1));
        in_pix_eff = flush ? '0 : in_pixel;
        rd_addr    = cur_col[ADDR_W-1:0];

        // The first item of a row emits the previous row's last pixel.
        if (!produce || col_nz)
        begin
            col_next = cur_col + COL_W'(1);
            row_next = cur_row;
        end
        else if (end_frame)
        begin
            col_next = '0;
            row_next = '0;
        end
        else
        begin
            col_next = COL_W'(1);
            row_next = cur_row;
        end
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            col_reg <= '0;
            row_reg <= '0;
        end
        else if (in_fire)
        begin
            col_reg <= col_next;
            row_reg <= row_next;
        end
    end

    // ------------------------------------------------------------------------
    // Line stores: read on accept, write when stage 1 moves on
    // ------------------------------------------------------------------------

    always_ff @(posedge clk)
    begin
        if (in_fire)
        begin
            up_rd_reg  <= upper_mem[rd_addr];
            mid_rd_reg <= middle_mem[rd_addr];
        end
        if (s1_adv)
        begin
            upper_mem[s1_addr_reg]  <= s1_mid;
            middle_mem[s1_addr_reg] <= s1_pix_reg;
        end
    end

    // Read data, replaced by the write that raced the read on the same column.
    assign s1_up  = s1_fwd_reg ? s1_fwd_up_reg  : up_rd_reg;
    assign s1_mid = s1_fwd_reg ? s1_fwd_mid_reg : mid_rd_reg;

    // ------------------------------------------------------------------------
    // Stage 1 control
    // ------------------------------------------------------------------------

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            s1_v_reg <= 1'b0;
        end
        else if (s1_free)
        begin
            s1_v_reg <= in_fire;
        end
    end

    always_ff @(posedge clk)
    begin
        if (in_fire)
        begin
            s1_addr_reg    <= rd_addr;
            s1_pix_reg     <= in_pix_eff;
            s1_prod_reg    <= produce;
            s1_med_reg     <= sel_med;
            s1_last_reg    <= end_frame;
            s1_fwd_reg     <= s1_adv && (s1_addr_reg == rd_addr);
            s1_fwd_up_reg  <= s1_mid;
            s1_fwd_mid_reg <= s1_pix_reg;
        end
    end

    // ------------------------------------------------------------------------
    // Window shift
    // ------------------------------------------------------------------------

    always_comb
    begin
        for (int k = 0; k < 3; k++)
        begin
            win_shift[k*3+0] = win_reg[k*3+1];
            win_shift[k*3+1] = win_reg[k*3+2];
        end
        win_shift[2] = s1_up;
        win_shift[5] = s1_mid;
        win_shift[8] = s1_pix_reg;
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            for (int i = 0; i < 9; i++)
            begin
                win_reg[i] <= '0;
            end
        end
        else if (s1_adv)
        begin
            for (int i = 0; i < 9; i++)
            begin
                win_reg[i] <= win_shift[i];
            end
        end
    end

    // ------------------------------------------------------------------------
    // Stage 2: snapshot of the shifted window, items without result dropped
    // ------------------------------------------------------------------------

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            s2_v_reg <= 1'b0;
        end
        else if (s2_free)
        begin
            s2_v_reg <= s1_v_reg && s1_prod_reg;
        end
    end

    // The border value is the old middle-right tap, i.e. the new center.
    always_ff @(posedge clk)
    begin
        if (s1_adv)
        begin
            s2_med_reg  <= s1_med_reg;
            s2_last_reg <= s1_last_reg;
            s2_bval_reg <= win_reg[5];
            for (int i = 0; i < 9; i++)
            begin
                s2_win_reg[i] <= win_shift[i];
            end
        end
    end

    // ------------------------------------------------------------------------
    // Stage 3: sort each window row
    // ------------------------------------------------------------------------

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            s3_v_reg <= 1'b0;
        end
        else if (s3_free)
        begin
            s3_v_reg <= s2_v_reg;
        end
    end

    always_ff @(posedge clk)
    begin
        if (s2_v_reg && s3_free)
        begin
            s3_med_reg  <= s2_med_reg;
            s3_last_reg <= s2_last_reg;
            s3_bval_reg <= s2_bval_reg;
            for (int k = 0; k < 3; k++)
            begin
                s3_lo_reg[k] <= min3(s2_win_reg[k*3], s2_win_reg[k*3+1], s2_win_reg[k*3+2]);
                s3_md_reg[k] <= med3(s2_win_reg[k*3], s2_win_reg[k*3+1], s2_win_reg[k*3+2]);
                s3_hi_reg[k] <= max3(s2_win_reg[k*3], s2_win_reg[k*3+1], s2_win_reg[k*3+2]);
            end
        end
    end

    // ------------------------------------------------------------------------
    // Stage 4: reduce the sorted rows to three candidates
    // ------------------------------------------------------------------------

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            s4_v_reg <= 1'b0;
        end
        else if (s4_free)
        begin
            s4_v_reg <= s3_v_reg;
        end
    end

    always_ff @(posedge clk)
    begin
        if (s3_v_reg && s4_free)
        begin
            s4_med_reg  <= s3_med_reg;
            s4_last_reg <= s3_last_reg;
            s4_bval_reg <= s3_bval_reg;
            s4_a_reg    <= max3(s3_lo_reg[0], s3_lo_reg[1], s3_lo_reg[2]);
            s4_b_reg    <= med3(s3_md_reg[0], s3_md_reg[1], s3_md_reg[2]);
            s4_c_reg    <= min3(s3_hi_reg[0], s3_hi_reg[1], s3_hi_reg[2]);
        end
    end

    // ------------------------------------------------------------------------
    // Output register: median of the candidates, or the border pixel
    // ------------------------------------------------------------------------

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            out_v_reg <= 1'b0;
        end
        else if (out_free)
        begin
            out_v_reg <= s4_v_reg;
        end
    end

    always_ff @(posedge clk)
    begin
        if (s4_v_reg && out_free)
        begin
            out_last_reg <= s4_last_reg;
            out_pix_reg  <= s4_med_reg ? med3(s4_a_reg, s4_b_reg, s4_c_reg)
                                       : s4_bval_reg;
        end
    end

    assign out_valid  = out_v_reg;
    assign out_pixel  = out_pix_reg;
    assign frame_last = out_last_reg;

endmodule

FILE: verif/median_filter_3x3_core_tb.sv
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// median_filter_3x3_core_tb
// Self-checking bench for the 3x3 median filter core. Frames are streamed
// over the valid/ready input with random idling on both channels. A local
// predictor mirrors the line stores, the window and the raster counters to
// work out every result. The register port is exercised with zero and
// minimal frame sizes, a wide and a tall frame, and changes inside a frame.
// ----------------------------------------------------------------------------
module median_filter_3x3_core_tb;

    import mf3_pkg::*;

    localparam int PIPE_SETTLE    = 12;
    localparam int WATCHDOG_LIMIT = 2000;

    typedef enum int
    {
        PX_UNIFORM,
        PX_NARROW,
        PX_EXTREME,
        PX_SPARSE
    } px_mode_t;

    typedef struct packed
    {
        pix_t pix;
        logic last;
    } filt_result_t;

    logic                  clk = 1'b0;
    logic                  rst_n = 1'b0;
    logic                  psel = 1'b0;
    logic                  penable = 1'b0;
    logic                  pwrite = 1'b0;
    logic [APB_ADDR_W-1:0] paddr = '0;
    logic [APB_DATA_W-1:0] pwdata = '0;
    logic [APB_DATA_W-1:0] prdata;
    logic                  pready;
    logic                  in_valid = 1'b0;
    logic                  in_ready;
    logic [PIX_W-1:0]      in_pixel = '0;
    logic                  flush = 1'b0;
    logic                  out_valid;
    logic                  out_ready = 1'b0;
    logic [PIX_W-1:0]      out_pixel;
    logic                  frame_last;

    // Predictor state: configuration, line stores, window and raster position.
    logic [CFG_W_W-1:0] width_reg = WIDTH_RST;
    logic [CFG_H_W-1:0] height_reg = HEIGHT_RST;
    pix_t               upper_store [MAX_WIDTH_DEF];
    pix_t               middle_store [MAX_WIDTH_DEF];
    pix_t               window_px [9];
    int unsigned        col_pos = 0;
    int unsigned        row_pos = 0;
    bit                 frame_closed = 1'b0;

    filt_result_t pending_out [$];
    filt_result_t next_result;
    int unsigned  error_count = 0;
    int unsigned  items_sent = 0;
    int unsigned  src_idle_pct = 0;
    int unsigned  sink_stall_pct = 0;
    int unsigned  quiet_cycles = 0;

    median_filter_3x3_core dut
    (
        .clk        (clk),
        .rst_n      (rst_n),
        .psel       (psel),
        .penable    (penable),
        .pwrite     (pwrite),
        .paddr      (paddr),
        .pwdata     (pwdata),
        .prdata     (prdata),
        .pready     (pready),
        .in_valid   (in_valid),
        .in_ready   (in_ready),
        .in_pixel   (in_pixel),
        .flush      (flush),
        .out_valid  (out_valid),
        .out_ready  (out_ready),
        .out_pixel  (out_pixel),
        .frame_last (frame_last)
    );

    always
    begin
        #2 clk = 1'b1;
        #2 clk = 1'b0;
    end

    // Effective frame size after clamping of out-of-range register values.
    function automatic int unsigned eff_width();
        if (width_reg == 0)
            return 1;
        if (width_reg > MAX_WIDTH_DEF)
            return MAX_WIDTH_DEF;
        return int'(width_reg);
    endfunction

    function automatic int unsigned eff_height();
        return (height_reg == 0) ? 1 : int'(height_reg);
    endfunction

    function automatic pix_t median_of_nine(input pix_t v [9]);
        pix_t s [9];
        pix_t t;
        s = v;
        for (int i = 1; i < 9; i++)
            for (int j = i; j > 0 && s[j-1] > s[j]; j--)
            begin
                t = s[j];
                s[j] = s[j-1];
                s[j-1] = t;
            end
        return s[4];
    endfunction

    // Advances the predicted filter by one accepted item and queues the
    // result it releases, if any.
    function automatic void filter_predict(input pix_t pix_in, input logic is_flush);
        int unsigned  w;
        int unsigned  h;
        int unsigned  c;
        int unsigned  r;
        pix_t         p;
        pix_t         right_px;
        pix_t         up_px;
        pix_t         mid_px;
        pix_t         val;
        logic         last;
        filt_result_t res;
        w = eff_width();
        h = eff_height();
        p = is_flush ? '0 : pix_in;
        if (col_pos >= w)
        begin
            col_pos = 0;
            row_pos++;
        end
        c = col_pos;
        r = row_pos;
        // The right column of the middle row still holds the last pixel of
        // the row before, which the first item of a row releases.
        right_px = window_px[5];
        up_px = upper_store[c];
        mid_px = middle_store[c];
        upper_store[c] = mid_px;
        middle_store[c] = p;
        for (int k = 0; k < 3; k++)
        begin
            window_px[k*3] = window_px[k*3+1];
            window_px[k*3+1] = window_px[k*3+2];
        end
        window_px[2] = up_px;
        window_px[5] = mid_px;
        window_px[8] = p;
        if (!(r >= 2 || (r == 1 && c >= 1)))
        begin
            col_pos = c + 1;
            return;
        end
        last = 1'b0;
        if (c >= 1)
        begin
            if (r == 1 || r - 1 >= h - 1 || c == 1 || c - 1 >= w - 1)
                val = window_px[4];
            else
                val = median_of_nine(window_px);
            col_pos = c + 1;
        end
        else
        begin
            val = right_px;
            if (r >= h + 1)
            begin
                last = 1'b1;
                col_pos = 0;
                row_pos = 0;
                frame_closed = 1'b1;
            end
            else
                col_pos = 1;
        end
        res.pix = val;
        res.last = last;
        pending_out.insert(pending_out.size(), res);
    endfunction

    function automatic pix_t rand_pixel(input px_mode_t mode);
        case (mode)
            PX_NARROW:  return pix_t'($urandom_range(135, 120));
            PX_EXTREME: return $urandom_range(1) ? 8'd255 : 8'd0;
            PX_SPARSE:
            begin
                case ($urandom_range(4))
                    0: return 8'd0;
                    1: return 8'd1;
                    2: return 8'd128;
                    3: return 8'd254;
                    default: return 8'd255;
                endcase
            end
            default:    return pix_t'($urandom_range(255));
        endcase
    endfunction

    // Result checker: every accepted result against the oldest prediction.
    always @(posedge clk)
    begin
        if (rst_n && out_valid && out_ready)
        begin
            if (pending_out.size() == 0)
            begin
                $error("unexpected result: out_pixel %0d frame_last %0b",
                       out_pixel, frame_last);
                error_count++;
            end
            else
            begin
                next_result = pending_out.pop_front();
                if (out_pixel !== next_result.pix)
                begin
                    $error("out_pixel: expected %0d, actual %0d",
                           next_result.pix, out_pixel);
                    error_count++;
                end
                if (frame_last !== next_result.last)
                begin
                    $error("frame_last: expected %0b, actual %0b",
                           next_result.last, frame_last);
                    error_count++;
                end
            end
        end
    end

    // Result sink with random back-pressure.
    always @(negedge clk)
    begin
        out_ready <= ($urandom_range(99) >= sink_stall_pct);
    end

    // Watchdog on cycles in which no transfer completes on any port.
    always @(posedge clk)
    begin
        if ((in_valid && in_ready) || (out_valid && out_ready) || (psel && penable))
            quiet_cycles <= 0;
        else
            quiet_cycles <= quiet_cycles + 1;
        if (quiet_cycles >= WATCHDOG_LIMIT)
        begin
            $display("Regression FAIL");
            $finish;
        end
    end

    task automatic set_idling(input int unsigned src_pct, input int unsigned sink_pct);
        src_idle_pct = src_pct;
        sink_stall_pct = sink_pct;
    endtask

    // Sends one item, with random idle cycles ahead of it.
    task automatic send_item(input pix_t pix, input logic is_flush);
        @(negedge clk);
        while ($urandom_range(99) < src_idle_pct)
        begin
            in_valid <= 1'b0;
            @(negedge clk);
        end
        in_valid <= 1'b1;
        in_pixel <= pix;
        flush <= is_flush;
        do
            @(posedge clk);
        while (!in_ready);
        filter_predict(pix, is_flush);
        items_sent++;
    endtask

    // Holds the input off until every predicted result has arrived, then
    // lets the pipeline settle.
    task automatic wait_idle();
        @(negedge clk);
        in_valid <= 1'b0;
        while (pending_out.size() != 0)
            @(posedge clk);
        repeat (PIPE_SETTLE) @(posedge clk);
    endtask

    task automatic read_reg(input cfg_reg_t idx, output logic [APB_DATA_W-1:0] data);
        @(negedge clk);
        psel <= 1'b1;
        penable <= 1'b0;
        pwrite <= 1'b0;
        paddr <= {idx, 2'b00};
        @(negedge clk);
        penable <= 1'b1;
        do
            @(posedge clk);
        while (!pready);
        data = prdata;
        @(negedge clk);
        psel <= 1'b0;
        penable <= 1'b0;
    endtask

    // Writes a register, mirrors it in the predictor and reads it back.
    task automatic program_reg(input cfg_reg_t idx, input logic [APB_DATA_W-1:0] value);
        logic [APB_DATA_W-1:0] readback;
        logic [APB_DATA_W-1:0] mask;
        mask = (idx == REG_WIDTH) ? (1 << CFG_W_W) - 1 : (1 << CFG_H_W) - 1;
        @(negedge clk);
        psel <= 1'b1;
        penable <= 1'b0;
        pwrite <= 1'b1;
        paddr <= {idx, 2'b00};
        pwdata <= value;
        @(negedge clk);
        penable <= 1'b1;
        do
            @(posedge clk);
        while (!pready);
        if (idx == REG_WIDTH)
            width_reg = value[CFG_W_W-1:0];
        else
            height_reg = value[CFG_H_W-1:0];
        @(negedge clk);
        psel <= 1'b0;
        penable <= 1'b0;
        pwrite <= 1'b0;
        read_reg(idx, readback);
        if ((readback & mask) !== (value & mask))
        begin
            $error("%s readback: expected %0d, actual %0d",
                   idx.name(), value & mask, readback & mask);
            error_count++;
        end
    endtask

    task automatic reconfigure(input int unsigned w, input int unsigned h);
        wait_idle();
        program_reg(REG_WIDTH, w);
        program_reg(REG_HEIGHT, h);
    endtask

    // Sends drain items until the predictor sees the frame close. Some of
    // them carry pixels instead of the flush flag.
    task automatic finish_frame(input int unsigned drain_pixel_pct);
        frame_closed = 1'b0;
        while (!frame_closed)
            send_item(pix_t'($urandom_range(255)), $urandom_range(99) >= drain_pixel_pct);
    endtask

    task automatic send_frame(input px_mode_t mode, input int unsigned flush_pct,
                              input int unsigned drain_pixel_pct);
        int unsigned n;
        n = eff_width() * eff_height();
        for (int unsigned i = 0; i < n; i++)
            send_item(rand_pixel(mode), $urandom_range(99) < flush_pct);
        finish_frame(drain_pixel_pct);
    endtask

    task automatic test_register_reset();
        logic [APB_DATA_W-1:0] v;
        read_reg(REG_WIDTH, v);
        if (v[CFG_W_W-1:0] !== WIDTH_RST)
        begin
            $error("image_width reset: expected %0d, actual %0d", WIDTH_RST, v[CFG_W_W-1:0]);
            error_count++;
        end
        read_reg(REG_HEIGHT, v);
        if (v[CFG_H_W-1:0] !== HEIGHT_RST)
        begin
            $error("image_height reset: expected %0d, actual %0d",
                   HEIGHT_RST, v[CFG_H_W-1:0]);
            error_count++;
        end
    endtask

    // A 4x3 frame of mostly extreme values with a flush item inside the frame and
    // drain items that alternate between flushes and pixels.
    task automatic test_directed_frame();
        pix_t frame_px [12];
        logic frame_fl [12];
        frame_px = '{8'd0, 8'd255, 8'd255, 8'd0,
                     8'd255, 8'hA5, 8'd255, 8'd1,
                     8'd128, 8'd255, 8'd0, 8'd254};
        frame_fl = '{0, 0, 0, 0, 0, 1, 0, 0, 0, 0, 0, 0};
        set_idling(0, 0);
        reconfigure(4, 3);
        for (int i = 0; i < 12; i++)
            send_item(frame_px[i], frame_fl[i]);
        for (int i = 0; i < 5; i++)
            send_item(8'h5A, i[0]);
    endtask

    // Zero width and height act as one; tiny frames, most with no interior.
    task automatic test_degenerate_sizes();
        set_idling(26, 26);
        reconfigure(0, 0);
        send_frame(PX_EXTREME, 0, 50);
        reconfigure(1, 1);
        send_frame(PX_UNIFORM, 0, 50);
        reconfigure(2, 2);
        send_frame(PX_SPARSE, 0, 50);
        reconfigure(1, 5);
        send_frame(PX_UNIFORM, 10, 50);
        reconfigure(3, 3);
        send_frame(PX_EXTREME, 0, 0);
    endtask

    // A frame well wider than the random ones, with a long drain.
    task automatic test_wide_frame();
        set_idling(26, 26);
        reconfigure(40, 2);
        send_frame(PX_SPARSE, 2, 30);
    endtask

    // A single-column frame with many rows under heavy back-pressure.
    task automatic test_tall_frame();
        set_idling(0, 79);
        reconfigure(1, 40);
        send_frame(PX_UNIFORM, 1, 30);
    endtask

    // Register changes part way through a frame, with the input paused
    // until all results are in.
    task automatic test_midframe_config();
        set_idling(26, 26);
        // Height shrinks below the current row.
        reconfigure(8, 6);
        for (int i = 0; i < 35; i++)
            send_item(rand_pixel(PX_UNIFORM), 1'b0);
        wait_idle();
        program_reg(REG_HEIGHT, 3);
        finish_frame(30);
        // Width shrinks below the current column, which forces a wrap.
        reconfigure(9, 5);
        for (int i = 0; i < 25; i++)
            send_item(rand_pixel(PX_NARROW), 1'b0);
        wait_idle();
        program_reg(REG_WIDTH, 4);
        for (int i = 0; i < 8; i++)
            send_item(rand_pixel(PX_NARROW), 1'b0);
        finish_frame(30);
        // Height grows after the frame has entered its drain rows.
        reconfigure(5, 2);
        for (int i = 0; i < 12; i++)
            send_item(rand_pixel(PX_SPARSE), 1'b0);
        wait_idle();
        program_reg(REG_HEIGHT, 4);
        for (int i = 0; i < 10; i++)
            send_item(rand_pixel(PX_SPARSE), 1'b0);
        finish_frame(30);
    endtask

    // Random frames, often back to back with no register change between.
    task automatic run_random_frames(input int unsigned item_budget);
        int unsigned stop_at;
        int unsigned w;
        int unsigned h;
        stop_at = items_sent + item_budget;
        while (items_sent < stop_at)
        begin
            if (eff_width() * eff_height() > 200 || $urandom_range(99) < 60)
            begin
                case ($urandom_range(9))
                    0:       w = $urandom_range(2, 1);
                    1:       w = $urandom_range(24, 9);
                    default: w = $urandom_range(8, 3);
                endcase
                h = ($urandom_range(4) == 0) ? $urandom_range(2, 1) : $urandom_range(6, 3);
                reconfigure(w, h);
            end
            send_frame(px_mode_t'($urandom_range(3)), ($urandom_range(3) == 0) ? 5 : 0, 30);
        end
    endtask

    task automatic test_random_traffic();
        set_idling(0, 0);
        run_random_frames(80);
        set_idling(79, 0);
        run_random_frames(80);
        set_idling(0, 79);
        run_random_frames(80);
        set_idling(26, 26);
        run_random_frames(80);
    endtask

    initial
    begin
        repeat (8) @(posedge clk);
        @(negedge clk);
        rst_n <= 1'b1;
        test_register_reset();
        test_directed_frame();
        test_degenerate_sizes();
        test_wide_frame();
        test_tall_frame();
        test_midframe_config();
        test_random_traffic();
        wait_idle();
        if (error_count == 0)
            $display("Regression PASS");
        else
            $display("Regression FAIL");
        $finish;
    end

endmodule

FILE: filelist.f
rtl/mf3_pkg.sv
rtl/median_filter_3x3_core.sv
verif/median_filter_3x3_core_tb.sv
